### rtl/amsl_pkg.sv
// Package for the 6502 addressing mode selector: codes, types and the legality table.
package amsl_pkg;

    // statement commands
    localparam logic [2:0] CMD_ORIGIN  = 3'd0;
    localparam logic [2:0] CMD_BYTES   = 3'd1;
    localparam logic [2:0] CMD_STRING  = 3'd2;
    localparam logic [2:0] CMD_INSTR   = 3'd3;
    localparam logic [2:0] CMD_SECTION = 3'd4;

    // operand syntax forms
    localparam logic [4:0] OK_INT        = 5'd0;
    localparam logic [4:0] OK_IDENT      = 5'd1;
    localparam logic [4:0] OK_INT_X      = 5'd2;
    localparam logic [4:0] OK_INT_Y      = 5'd3;
    localparam logic [4:0] OK_IDENT_X    = 5'd4;
    localparam logic [4:0] OK_IDENT_Y    = 5'd5;
    localparam logic [4:0] OK_REL_INT    = 5'd6;
    localparam logic [4:0] OK_REL_IDENT  = 5'd7;
    localparam logic [4:0] OK_IND_INT_Y  = 5'd8;
    localparam logic [4:0] OK_IND_INT_X  = 5'd9;
    localparam logic [4:0] OK_IND_ID_Y   = 5'd10;
    localparam logic [4:0] OK_IND_ID_X   = 5'd11;
    localparam logic [4:0] OK_ACCUM      = 5'd12;
    localparam logic [4:0] OK_IMM_INT    = 5'd13;
    localparam logic [4:0] OK_IMM_IDENT  = 5'd14;
    localparam logic [4:0] OK_IND_INT    = 5'd15;
    localparam logic [4:0] OK_IND_IDENT  = 5'd16;
    localparam logic [4:0] OK_IMPLICIT   = 5'd17;

    // mnemonics with special mode rules
    localparam logic [5:0] MN_JMP = 6'd26;
    localparam logic [5:0] MN_JSR = 6'd27;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_ORIGIN    = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd2;
    localparam logic [1:0] ERR_BAD_MODE  = 2'd3;

    typedef enum logic [3:0] {
        AM_IMP = 4'd0,
        AM_ACC = 4'd1,
        AM_IMM = 4'd2,
        AM_ZP  = 4'd3,
        AM_ZPX = 4'd4,
        AM_ZPY = 4'd5,
        AM_ABS = 4'd6,
        AM_ABX = 4'd7,
        AM_ABY = 4'd8,
        AM_IND = 4'd9,
        AM_INX = 4'd10,
        AM_INY = 4'd11,
        AM_REL = 4'd12,
        AM_BAD = 4'd13
    } t_amode;

    // decoder result handed to the top level
    typedef struct packed {
        t_amode     mode;
        logic       unknown_ident;
        logic       illegal;
        logic [1:0] op_bytes;
    } t_mode_res;

    localparam int unsigned IN_W  = 48;
    localparam int unsigned OUT_W = 48;

    // legal mode masks, one bit per t_amode code
    localparam logic [15:0] LM_IMM    = 16'h0004;
    localparam logic [15:0] LM_REL    = 16'h1000;
    localparam logic [15:0] LM_GRP1   = 16'h0DDC;
    localparam logic [15:0] LM_SHIFT  = 16'h00DA;
    localparam logic [15:0] LM_ZP_ABS = 16'h0048;
    localparam logic [15:0] LM_I_ZA   = 16'h004C;
    localparam logic [15:0] LM_ZX_AX  = 16'h00D8;
    localparam logic [15:0] LM_JMP    = 16'h0240;
    localparam logic [15:0] LM_ABS    = 16'h0040;
    localparam logic [15:0] LM_LDX    = 16'h016C;
    localparam logic [15:0] LM_LDY    = 16'h00DC;
    localparam logic [15:0] LM_STA    = 16'h0DD8;
    localparam logic [15:0] LM_STX    = 16'h0068;
    localparam logic [15:0] LM_STY    = 16'h0058;
    localparam logic [15:0] LM_NONE   = 16'h0000;

    function automatic logic [15:0] legal_modes(input logic [5:0] mn);
        logic [15:0] m;
        case (mn)
            6'd0, 6'd1, 6'd16, 6'd22, 6'd32, 6'd41, 6'd54: m = LM_GRP1;
            6'd2, 6'd30, 6'd37, 6'd38:                     m = LM_SHIFT;
            6'd3, 6'd4, 6'd5, 6'd7, 6'd8, 6'd9, 6'd11, 6'd12: m = LM_REL;
            6'd6:                                          m = LM_ZP_ABS;
            6'd10, 6'd13, 6'd14, 6'd15, 6'd20, 6'd21, 6'd24, 6'd25,
            6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd39, 6'd40, 6'd42,
            6'd43, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53,
            6'd55:                                         m = LM_IMM;
            6'd17, 6'd18:                                  m = LM_I_ZA;
            6'd19, 6'd23:                                  m = LM_ZX_AX;
            6'd26:                                         m = LM_JMP;
            6'd27:                                         m = LM_ABS;
            6'd28:                                         m = LM_LDX;
            6'd29:                                         m = LM_LDY;
            6'd44:                                         m = LM_STA;
            6'd45:                                         m = LM_STX;
            6'd46:                                         m = LM_STY;
            default:                                       m = LM_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] operand_bytes(input t_amode md);
        logic [1:0] b;
        case (md)
            AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_INX, AM_INY, AM_REL: b = 2'd1;
            AM_ABS, AM_ABX, AM_ABY, AM_IND:                       b = 2'd2;
            default:                                              b = 2'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/amsl_mode_decode.sv
// Addressing mode selection and legality check for one instruction statement.
module amsl_mode_decode
    import amsl_pkg::*;
(
    input  logic [4:0]  i_operand_kind,
    input  logic [5:0]  i_mnemonic,
    input  logic [15:0] i_operand_value,
    input  logic        i_label_ref,
    input  logic        i_name_found,
    output t_mode_res   o_res
);

    logic   wide;
    logic   ident;
    logic   far;
    logic   jump;
    logic   branch;
    t_amode mode;
    logic [15:0] legal;

    assign wide   = (i_operand_value[15:8] != 8'd0);
    assign jump   = (i_mnemonic == MN_JMP) || (i_mnemonic == MN_JSR);
    assign branch = (i_mnemonic == 6'd3) || (i_mnemonic == 6'd4) || (i_mnemonic == 6'd5) ||
                    (i_mnemonic == 6'd7) || (i_mnemonic == 6'd8) || (i_mnemonic == 6'd9) ||
                    (i_mnemonic == 6'd11) || (i_mnemonic == 6'd12);
    assign ident  = (i_operand_kind == OK_IDENT) || (i_operand_kind == OK_IDENT_X) ||
                    (i_operand_kind == OK_IDENT_Y) || (i_operand_kind == OK_REL_IDENT) ||
                    (i_operand_kind == OK_IND_ID_Y) || (i_operand_kind == OK_IND_ID_X) ||
                    (i_operand_kind == OK_IMM_IDENT) || (i_operand_kind == OK_IND_IDENT);
    // label flag only matters for identifier forms
    assign far    = (ident && i_label_ref) || wide;
    assign legal  = legal_modes(i_mnemonic);

    always_comb begin
        case (i_operand_kind)
            OK_INT:       mode = (jump || wide) ? AM_ABS : AM_ZP;
            OK_IDENT: begin
                if (branch) begin
                    mode = AM_REL;
                end else begin
                    mode = (jump || far) ? AM_ABS : AM_ZP;
                end
            end
            OK_INT_X:     mode = wide ? AM_ABX : AM_ZPX;
            OK_INT_Y:     mode = wide ? AM_ABY : AM_ZPY;
            OK_IDENT_X:   mode = far ? AM_ABX : AM_ZPX;
            OK_IDENT_Y:   mode = far ? AM_ABY : AM_ZPY;
            OK_REL_INT,
            OK_REL_IDENT: mode = AM_REL;
            OK_IND_INT_Y: mode = wide ? AM_BAD : AM_INY;
            OK_IND_INT_X: mode = wide ? AM_BAD : AM_INX;
            OK_IND_ID_Y:  mode = far ? AM_BAD : AM_INY;
            OK_IND_ID_X:  mode = far ? AM_BAD : AM_INX;
            OK_ACCUM:     mode = AM_ACC;
            OK_IMM_INT:   mode = wide ? AM_BAD : AM_IMM;
            OK_IMM_IDENT: mode = far ? AM_BAD : AM_IMM;
            OK_IND_INT,
            OK_IND_IDENT: mode = AM_IND;
            OK_IMPLICIT:  mode = AM_IMP;
            default:      mode = AM_BAD;
        endcase

        o_res = '0;
        if (ident && !i_name_found) begin
            o_res.mode          = AM_BAD;
            o_res.unknown_ident = 1'b1;
        end else begin
            o_res.mode     = mode;
            o_res.op_bytes = operand_bytes(mode);
            // implicit form skips the legality check; invalid mode never has a bit
            o_res.illegal  = (i_operand_kind != OK_IMPLICIT) &&
                             ((mode == AM_BAD) || !legal[mode]);
        end
    end

endmodule

### rtl/asm_amode_select_location_counter.sv
// Top level: 6502 statement checker with location and section counters.
//
// One parsed assembler statement enters per transfer on the s_axis channel and
// exactly one result leaves per statement on the m_axis channel, in order.
// The statement is decoded and the counters updated in the cycle it is taken;
// its result is registered into the output register, or into the skid entry
// if the receiver stalls. Throughput is one statement per cycle while tready is high;
// the location counter adder and the mode decode form the single loop that sets this figure.
// A result register plus one skid entry sit on the output: while the receiver
// stalls, one more statement is taken into the skid entry, after which
// o_s_axis_tready drops until the receiver takes a result.
// Reset (synchronous, active low) clears the location counter, the section
// counter and the last-write record, and empties the output buffer.
// Result item_offset is the counter at the start of the statement,
// section_index the section count before any section statement bumps it.
module asm_amode_select_location_counter
    import amsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [2:0] command, [7:3] operand_kind, [13:8] mnemonic, [29:14] operand_value,
    // [30] label_ref, [31] name_found, [47:32] data_length
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [31:0] item_offset, [39:32] section_index, [43:40] address_mode,
    // [45:44] error_code, [47:46] zero
    output logic [OUT_W-1:0]  o_m_axis_tdata
);

    logic [2:0]  in_cmd;
    logic [4:0]  in_kind;
    logic [5:0]  in_mn;
    logic [15:0] in_value;
    logic        in_label;
    logic        in_found;
    logic [15:0] in_len;
    t_mode_res   dec;

    logic [31:0] r_loc, n_loc;
    logic [7:0]  r_section, n_section;
    logic [31:0] r_last_off, n_last_off;
    logic [7:0]  r_last_sec, n_last_sec;
    logic        r_last_valid, n_last_valid;

    logic             r_out_valid, r_skid_valid;
    logic [OUT_W-1:0] r_out_data, r_skid_data;
    logic [OUT_W-1:0] result;
    t_amode           res_mode;
    logic [1:0]       res_err;
    logic             accept;
    logic             out_free;

    assign in_cmd   = i_s_axis_tdata[2:0];
    assign in_kind  = i_s_axis_tdata[7:3];
    assign in_mn    = i_s_axis_tdata[13:8];
    assign in_value = i_s_axis_tdata[29:14];
    assign in_label = i_s_axis_tdata[30];
    assign in_found = i_s_axis_tdata[31];
    assign in_len   = i_s_axis_tdata[47:32];

    amsl_mode_decode u_decode (
        .i_operand_kind  (in_kind),
        .i_mnemonic      (in_mn),
        .i_operand_value (in_value),
        .i_label_ref     (in_label),
        .i_name_found    (in_found),
        .o_res           (dec)
    );

    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_loc        = r_loc;
        n_section    = r_section;
        n_last_off   = r_last_off;
        n_last_sec   = r_last_sec;
        n_last_valid = r_last_valid;
        res_mode     = AM_IMP;
        res_err      = ERR_NONE;
        case (in_cmd)
            CMD_ORIGIN: begin
                if (r_last_valid && (r_last_off >= {16'd0, in_value}) &&
                    (r_last_sec == r_section)) begin
                    res_err = ERR_ORIGIN;
                end else begin
                    n_loc = {16'd0, in_value};
                end
            end
            CMD_BYTES, CMD_STRING: begin
                n_loc = r_loc + {16'd0, in_len};
            end
            CMD_INSTR: begin
                res_mode = dec.mode;
                if (dec.unknown_ident) begin
                    res_err = ERR_UNKNOWN;
                end else begin
                    if (dec.illegal) begin
                        res_err = ERR_BAD_MODE;
                    end
                    n_loc = r_loc + 32'd1 + {30'd0, dec.op_bytes};
                end
            end
            CMD_SECTION: begin
                n_section = r_section + 8'd1;
            end
            default: begin
            end
        endcase
        if ((in_cmd == CMD_BYTES) || (in_cmd == CMD_STRING) || (in_cmd == CMD_INSTR)) begin
            n_last_off   = r_loc;
            n_last_sec   = r_section;
            n_last_valid = 1'b1;
        end
        result = {2'b00, res_err, res_mode, r_section, r_loc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc        <= '0;
            r_section    <= '0;
            r_last_off   <= '0;
            r_last_sec   <= '0;
            r_last_valid <= 1'b0;
        end else if (accept) begin
            r_loc        <= n_loc;
            r_section    <= n_section;
            r_last_off   <= n_last_off;
            r_last_sec   <= n_last_sec;
            r_last_valid <= n_last_valid;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end
        if (!out_free && accept) begin
            r_skid_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while output register is empty");

    a_section_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_cmd == CMD_SECTION)) |=> (r_section == $past(r_section) + 8'd1))
        else $error("section statement did not advance the section count");

    a_unknown_holds_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_cmd == CMD_INSTR) && dec.unknown_ident) |=> (r_loc == $past(r_loc)))
        else $error("unknown identifier moved the location counter");

    a_write_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((in_cmd == CMD_BYTES) || (in_cmd == CMD_STRING) || (in_cmd == CMD_INSTR)))
        |=> (r_last_valid && (r_last_off == $past(r_loc))))
        else $error("writable statement not recorded as last write");
`endif

endmodule

### tb/tb.sv
// Self-checking bench for the 6502 statement checker: addressing modes, errors, counters.
module tb;
    import amsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 450;
    localparam logic [2:0] CMD_OTHER = 3'd5;
    localparam logic [5:0] MN_ADC = 6'd0;
    localparam logic [5:0] MN_ASL = 6'd2;
    localparam logic [5:0] MN_BCC = 6'd3;
    localparam logic [5:0] MN_BCS = 6'd4;
    localparam logic [5:0] MN_LDX = 6'd28;
    localparam logic [5:0] MN_STX = 6'd45;
    localparam logic [5:0] MN_CLD = 6'd55;
    localparam logic [5:0] MN_SPARE_TOP = 6'd63;

    // one bit per addressing mode
    localparam logic [15:0] B_ACC = 16'h1 << AM_ACC;
    localparam logic [15:0] B_IMM = 16'h1 << AM_IMM;
    localparam logic [15:0] B_ZP  = 16'h1 << AM_ZP;
    localparam logic [15:0] B_ZPX = 16'h1 << AM_ZPX;
    localparam logic [15:0] B_ZPY = 16'h1 << AM_ZPY;
    localparam logic [15:0] B_ABS = 16'h1 << AM_ABS;
    localparam logic [15:0] B_ABX = 16'h1 << AM_ABX;
    localparam logic [15:0] B_ABY = 16'h1 << AM_ABY;
    localparam logic [15:0] B_IND = 16'h1 << AM_IND;
    localparam logic [15:0] B_INX = 16'h1 << AM_INX;
    localparam logic [15:0] B_INY = 16'h1 << AM_INY;
    localparam logic [15:0] B_REL = 16'h1 << AM_REL;
    localparam logic [15:0] M_ALU = B_IMM | B_ZP | B_ZPX | B_ABS | B_ABX | B_ABY | B_INX | B_INY;
    localparam logic [15:0] M_SHIFT = B_ACC | B_ZP | B_ZPX | B_ABS | B_ABX;

    // same layout as the input tdata, command in the low bits
    typedef struct packed {
        logic [15:0] data_len;
        logic        name_found;
        logic        label_ref;
        logic [15:0] value;
        logic [5:0]  mnem;
        logic [4:0]  kind;
        logic [2:0]  cmd;
    } t_stmt;

    // same layout as the output tdata
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  err;
        t_amode      mode;
        logic [7:0]  section;
        logic [31:0] offset;
    } t_stmt_res;

    typedef struct {
        t_stmt     st;
        bit        typed;
        t_stmt_res want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [47:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [47:0] m_data;

    // predictor state
    logic [31:0] loc_ctr = '0;
    logic [7:0]  sect_ctr = '0;
    logic [31:0] lw_off = '0;
    logic [7:0]  lw_sect = '0;
    logic        lw_valid = 1'b0;

    t_stmt_res   pending_res[$];
    t_dir_row    dir_tbl[$];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned n_items = 0;
    int unsigned n_checked = 0;
    int unsigned n_bad = 0;
    int unsigned n_err[4] = '{0, 0, 0, 0};
    int unsigned n_sect = 0;
    int unsigned cycles = 0;

    asm_amode_select_location_counter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_res.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [15:0] legal_mask(logic [5:0] mn);
        logic [15:0] m;
        case (mn)
            6'd0, 6'd1, 6'd16, 6'd22, 6'd32, 6'd41, 6'd54:       m = M_ALU;
            6'd44:                                               m = M_ALU & ~B_IMM;
            6'd2, 6'd30, 6'd37, 6'd38:                           m = M_SHIFT;
            6'd3, 6'd4, 6'd5, 6'd7, 6'd8, 6'd9, 6'd11, 6'd12:    m = B_REL;
            6'd6:                                                m = B_ZP | B_ABS;
            6'd17, 6'd18:                                        m = B_IMM | B_ZP | B_ABS;
            6'd19, 6'd23:                                        m = B_ZP | B_ZPX | B_ABS | B_ABX;
            6'd26:                                               m = B_ABS | B_IND;
            6'd27:                                               m = B_ABS;
            6'd28:                      m = B_IMM | B_ZP | B_ZPY | B_ABS | B_ABY;
            6'd29:                      m = B_IMM | B_ZP | B_ZPX | B_ABS | B_ABX;
            6'd45:                                               m = B_ZP | B_ZPY | B_ABS;
            6'd46:                                               m = B_ZP | B_ZPX | B_ABS;
            default:                    m = (mn > MN_CLD) ? 16'h0 : B_IMM;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] operand_size(t_amode md);
        case (md)
            AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_INX, AM_INY, AM_REL: return 2'd1;
            AM_ABS, AM_ABX, AM_ABY, AM_IND:                       return 2'd2;
            default:                                              return 2'd0;
        endcase
    endfunction

    function automatic bit ident_kind(logic [4:0] k);
        case (k)
            OK_IDENT, OK_IDENT_X, OK_IDENT_Y, OK_REL_IDENT, OK_IND_ID_Y, OK_IND_ID_X,
            OK_IMM_IDENT, OK_IND_IDENT: return 1'b1;
            default:                    return 1'b0;
        endcase
    endfunction

    function automatic t_amode pick_mode(logic [4:0] k, logic [5:0] mn, logic [15:0] v,
                                         logic lbl);
        bit wide;
        bit far;
        bit jump;
        bit branch;
        wide = (v > 16'h00FF);
        far = lbl || wide;
        jump = (mn == MN_JMP) || (mn == MN_JSR);
        // branches are exactly the relative-only mnemonics
        branch = (legal_mask(mn) == B_REL);
        case (k)
            OK_INT:       return (jump || wide) ? AM_ABS : AM_ZP;
            OK_IDENT:     return branch ? AM_REL : ((jump || far) ? AM_ABS : AM_ZP);
            OK_INT_X:     return wide ? AM_ABX : AM_ZPX;
            OK_INT_Y:     return wide ? AM_ABY : AM_ZPY;
            OK_IDENT_X:   return far ? AM_ABX : AM_ZPX;
            OK_IDENT_Y:   return far ? AM_ABY : AM_ZPY;
            OK_REL_INT, OK_REL_IDENT: return AM_REL;
            OK_IND_INT_Y: return wide ? AM_BAD : AM_INY;
            OK_IND_INT_X: return wide ? AM_BAD : AM_INX;
            OK_IND_ID_Y:  return far ? AM_BAD : AM_INY;
            OK_IND_ID_X:  return far ? AM_BAD : AM_INX;
            OK_ACCUM:     return AM_ACC;
            OK_IMM_INT:   return wide ? AM_BAD : AM_IMM;
            OK_IMM_IDENT: return far ? AM_BAD : AM_IMM;
            OK_IND_INT, OK_IND_IDENT: return AM_IND;
            OK_IMPLICIT:  return AM_IMP;
            default:      return AM_BAD;
        endcase
    endfunction

    // expected result of one statement; advances the predictor state
    function automatic t_stmt_res assemble_stmt(t_stmt s);
        logic [31:0] start;
        logic [15:0] allowed;
        t_stmt_res   r;
        logic        lbl;
        start = loc_ctr;
        r = '0;
        r.mode = AM_IMP;
        r.err = ERR_NONE;
        lbl = s.label_ref;
        case (s.cmd)
            CMD_ORIGIN: begin
                if (lw_valid && lw_off >= {16'h0, s.value} && lw_sect == sect_ctr)
                    r.err = ERR_ORIGIN;
                else
                    loc_ctr = {16'h0, s.value};
            end
            CMD_BYTES, CMD_STRING: loc_ctr = start + {16'h0, s.data_len};
            CMD_INSTR: begin
                if (s.kind == OK_IMPLICIT) begin
                    loc_ctr = start + 32'd1;
                end else if (ident_kind(s.kind) && !s.name_found) begin
                    r.err = ERR_UNKNOWN;
                    r.mode = AM_BAD;
                end else begin
                    if (!ident_kind(s.kind))
                        lbl = 1'b0;
                    r.mode = pick_mode(s.kind, s.mnem, s.value, lbl);
                    allowed = legal_mask(s.mnem);
                    if (!allowed[r.mode])
                        r.err = ERR_BAD_MODE;
                    loc_ctr = start + 32'd1 + {30'h0, operand_size(r.mode)};
                end
            end
            CMD_SECTION: sect_ctr = sect_ctr + 8'd1;
            default: ;
        endcase
        if (s.cmd == CMD_BYTES || s.cmd == CMD_STRING || s.cmd == CMD_INSTR) begin
            lw_off = start;
            lw_sect = sect_ctr;
            lw_valid = 1'b1;
        end
        r.offset = start;
        r.section = (s.cmd == CMD_SECTION) ? sect_ctr - 8'd1 : sect_ctr;
        return r;
    endfunction

    function automatic t_stmt mk_stmt(logic [2:0] c, logic [4:0] k, logic [5:0] mn,
                                      logic [15:0] v, logic lbl, logic fnd,
                                      logic [15:0] len);
        t_stmt s;
        s.cmd = c;
        s.kind = k;
        s.mnem = mn;
        s.value = v;
        s.label_ref = lbl;
        s.name_found = fnd;
        s.data_len = len;
        return s;
    endfunction

    function automatic t_stmt_res mk_res(logic [31:0] off, logic [7:0] sec, t_amode md,
                                         logic [1:0] e);
        t_stmt_res r;
        r.pad = 2'b00;
        r.err = e;
        r.mode = md;
        r.section = sec;
        r.offset = off;
        return r;
    endfunction

    // mostly well-formed statements with random content, some noise
    function automatic t_stmt random_stmt();
        logic [63:0] raw;
        t_stmt       s;
        int unsigned pick;
        raw = {$urandom(), $urandom()};
        s = raw[47:0];
        pick = $urandom_range(99);
        if (pick < 55) begin
            s.cmd = CMD_INSTR;
            s.kind = 5'($urandom_range(17));
            s.mnem = ($urandom_range(19) == 0) ? 6'($urandom()) : 6'($urandom_range(55));
            case ($urandom_range(3))
                0, 1: s.value = 16'($urandom_range(255));
                2:    s.value = 16'($urandom());
                default: begin
                    case ($urandom_range(3))
                        0: s.value = 16'h0000;
                        1: s.value = 16'h00FF;
                        2: s.value = 16'h0100;
                        default: s.value = 16'hFFFF;
                    endcase
                end
            endcase
            s.name_found = ($urandom_range(9) != 0);
        end else if (pick < 63) begin
            s.cmd = CMD_ORIGIN;
            if ($urandom_range(3) != 0)
                s.value = loc_ctr[15:0] + 16'($urandom_range(64));
        end else if (pick < 78) begin
            s.cmd = ($urandom_range(1) == 0) ? CMD_BYTES : CMD_STRING;
            if ($urandom_range(7) != 0)
                s.data_len = 16'($urandom_range(16));
        end else if (pick < 84) begin
            s.cmd = CMD_SECTION;
        end else if (pick < 90) begin
            s.cmd = CMD_OTHER + 3'($urandom_range(2));
        end
        return s;
    endfunction

    task automatic send_stmt(t_stmt s, bit typed, t_stmt_res want);
        t_stmt_res r;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= s;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        r = assemble_stmt(s);
        n_err[r.err]++;
        if (s.cmd == CMD_SECTION)
            n_sect++;
        n_items++;
        pending_res.push_back(typed ? want : r);
    endtask

    // called in the step of the last transfer: drops valid, then waits until no result is pending
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_stmt_res got;
        t_stmt_res want;
        if (i_rst_n && m_valid && m_ready) begin
            got = t_stmt_res'(m_data);
            if (pending_res.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: off=%h sec=%h mode=%0d err=%0d",
                             got.offset, got.section, got.mode, got.err);
            end else begin
                want = pending_res.pop_front();
                n_checked++;
                if (got.offset != want.offset || got.section != want.section ||
                    got.mode != want.mode || got.err != want.err || got.pad != 2'b00) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"mismatch @%0d: want off=%h sec=%h mode=%0d err=%0d, ",
                                  "got off=%h sec=%h mode=%0d err=%0d pad=%b"},
                                 n_checked, want.offset, want.section, want.mode, want.err,
                                 got.offset, got.section, got.mode, got.err, got.pad);
                end
            end
        end
    end

    initial begin
        // directed rows; typed expectations only where obvious from reset
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IMPLICIT, MN_CLD, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h0, 8'h0, AM_IMP, ERR_NONE)});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IMM_INT, MN_ADC, 16'h00FF, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h1, 8'h0, AM_IMM, ERR_NONE)});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IMM_INT, MN_ADC, 16'h0100, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h3, 8'h0, AM_BAD, ERR_BAD_MODE)});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IDENT, MN_ADC, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h4, 8'h0, AM_BAD, ERR_UNKNOWN)});
        dir_tbl.push_back('{mk_stmt(CMD_ORIGIN, OK_INT, MN_ADC, 16'h0004, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h4, 8'h0, AM_IMP, ERR_ORIGIN)});
        dir_tbl.push_back('{mk_stmt(CMD_ORIGIN, OK_INT, MN_ADC, 16'h1000, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h4, 8'h0, AM_IMP, ERR_NONE)});
        dir_tbl.push_back('{mk_stmt(CMD_BYTES, OK_INT, MN_ADC, 16'h0, 1'b0, 1'b0, 16'hFFFF),
                            1'b1, mk_res(32'h1000, 8'h0, AM_IMP, ERR_NONE)});
        dir_tbl.push_back('{mk_stmt(CMD_STRING, OK_INT, MN_ADC, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b1, mk_res(32'h10FFF, 8'h0, AM_IMP, ERR_NONE)});
        // jump forces absolute; label ignored on integer operand forms
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_INT, MN_JMP, 16'h0010, 1'b1, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_INT_X, MN_ADC, 16'h0010, 1'b1, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IDENT, MN_BCC, 16'h1234, 1'b1, 1'b1, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_REL_INT, MN_BCS, 16'hFFFF, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        // indexed-indirect identifier gives (ind,X)
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IND_ID_X, MN_ADC, 16'h0020, 1'b0, 1'b1, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IND_ID_Y, MN_ADC, 16'h0020, 1'b1, 1'b1, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_ACCUM, MN_ASL, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IND_INT, MN_JMP, 16'hABCD, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IND_INT_X, MN_ADC, 16'hFFFF, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_INT_X, MN_STX, 16'h0080, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_IDENT_Y, MN_LDX, 16'h0001, 1'b1, 1'b1, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, OK_INT, MN_SPARE_TOP, 16'h0001, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_INSTR, 5'd31, MN_ADC, 16'h0001, 1'b0, 1'b1, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(CMD_SECTION, OK_INT, MN_ADC, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        // new section: an origin behind the counter is accepted
        dir_tbl.push_back('{mk_stmt(CMD_ORIGIN, OK_INT, MN_ADC, 16'h0000, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(3'd7, 5'h1F, 6'h3F, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF),
                            1'b0, '0});
        dir_tbl.push_back('{mk_stmt(3'd6, 5'h0, 6'h0, 16'h0, 1'b0, 1'b0, 16'h0),
                            1'b0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i])
            send_stmt(dir_tbl[i].st, dir_tbl[i].typed, dir_tbl[i].want);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_stmt(random_stmt(), 1'b0, '0);
            drain_results();
        end

        // let any stray result show up
        repeat (8) @(posedge i_clk);
        $display("covered %0d statements (%0d directed), %0d results checked, %s",
                 n_items, dir_tbl.size(), n_checked, "four idle/stall mixes");
        $display("seen %0d origin refusals, %0d unknown identifiers, %0d bad modes, %0d sections",
                 n_err[ERR_ORIGIN], n_err[ERR_UNKNOWN], n_err[ERR_BAD_MODE], n_sect);
        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/amsl_pkg.sv
rtl/amsl_mode_decode.sv
rtl/asm_amode_select_location_counter.sv
tb/tb.sv
